>>> hdl/sts_pkg.sv
// shared constants and types for the sorted table search block
package sts_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 2;
   localparam int RSP_FIELD_W = 1 + IDX_W + CNT_W + 1;
   localparam int RSP_W       = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      REQ_LOAD   = 2'd0,
      REQ_SEARCH = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_RD,
      ST_SORT_GET,
      ST_SORT_SCAN,
      ST_SORT_WB,
      ST_SRCH_START,
      ST_SRCH_CMP,
      ST_DONE
   } sts_state_type;

endpackage

>>> hdl/sts_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/sorted_table_binary_search.sv
// top level of the sorted table with exchange sort and binary search
// load and clear transactions are taken in idle and give no result
// a search on a sorted table goes through start, one ram read per probe (at most
// log2(depth)+1 probes, 7 for 64 entries), then done holds until the output slot is free
// the first search after a load sorts first, with one ram read per sweep step
// reset clears count, overflow and the fsm and marks the table sorted; contents are kept

module sorted_table_binary_search (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sts_pkg::DATA_W-1:0]    req_tdata,  // [31:0] value
   input  logic [sts_pkg::KIND_W-1:0]    req_tuser,  // [1:0] req_type
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sts_pkg::RSP_W-1:0]     rsp_tdata   // [0] found, [6:1] position,
                                                     // [13:7] table_count, [14] overflow
);

   localparam int IDX_W = sts_pkg::IDX_W;
   localparam int CNT_W = sts_pkg::CNT_W;

   // control state
   sts_pkg::sts_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   sorted_ff, sorted_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [sts_pkg::DATA_W-1:0] key_ff, key_in;
   logic [sts_pkg::DATA_W-1:0] pivot_ff, pivot_in;   // entry i held while x sweeps
   logic [IDX_W-1:0]           i_ff, i_in;
   logic [IDX_W-1:0]           x_ff, x_in;
   logic [CNT_W-1:0]           lo_ff, lo_in;         // search window is [lo, lim)
   logic [CNT_W-1:0]           lim_ff, lim_in;
   logic [IDX_W-1:0]           mid_ff, mid_in;
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           pos_ff, pos_in;
   logic [sts_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // ram port
   logic                       ram_we;
   logic [IDX_W-1:0]           ram_wr_addr;
   logic [sts_pkg::DATA_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]           ram_rd_addr;
   logic [sts_pkg::DATA_W-1:0] ram_rd_data;

   // decisions used by next state and datapath
   logic             req_fire;
   logic             x_last;
   logic             i_last;
   logic             probe_hit;
   logic             probe_gt;
   logic [CNT_W-1:0] step_lo;
   logic [CNT_W-1:0] step_lim;
   logic [CNT_W:0]   step_sum;
   logic [IDX_W-1:0] step_mid;
   logic             step_go;
   logic             rsp_slot_free;

   sts_ram #(
      .WIDTH (sts_pkg::DATA_W),
      .DEPTH (sts_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready    = (state_ff == sts_pkg::ST_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign rsp_slot_free = !rsp_valid_ff || rsp_tready;

   // sweep ends at the last held entry
   assign x_last = ({1'b0, x_ff} == (count_ff - CNT_W'(1)));
   assign i_last = ({1'b0, i_ff} == (count_ff - CNT_W'(1)));

   // probe compare, read data belongs to mid_ff
   assign probe_hit = (state_ff == sts_pkg::ST_SRCH_CMP) &&
                      ($signed(ram_rd_data) == $signed(key_ff));
   assign probe_gt  = $signed(ram_rd_data) > $signed(key_ff);

   // next search window and its midpoint
   always_comb begin
      step_lo  = lo_ff;
      step_lim = lim_ff;
      case (state_ff)
         sts_pkg::ST_SRCH_START: begin
            step_lo  = '0;
            step_lim = count_ff;
         end
         sts_pkg::ST_SRCH_CMP: begin
            if (probe_gt) begin
               step_lim = CNT_W'(mid_ff);
            end else begin
               step_lo = CNT_W'(mid_ff) + CNT_W'(1);
            end
         end
         default: begin
            step_lo  = lo_ff;
            step_lim = lim_ff;
         end
      endcase
      step_go  = step_lo < step_lim;
      step_sum = {1'b0, step_lo} + {1'b0, step_lim} - (CNT_W + 1)'(1);
      step_mid = step_sum[IDX_W:1];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sts_pkg::ST_IDLE: begin
            if (req_fire && (req_tuser == sts_pkg::REQ_SEARCH)) begin
               state_in = sorted_ff ? sts_pkg::ST_SRCH_START : sts_pkg::ST_SORT_RD;
            end
         end
         sts_pkg::ST_SORT_RD:   state_in = sts_pkg::ST_SORT_GET;
         sts_pkg::ST_SORT_GET:  state_in = sts_pkg::ST_SORT_SCAN;
         sts_pkg::ST_SORT_SCAN: begin
            if (x_last) begin
               state_in = sts_pkg::ST_SORT_WB;
            end
         end
         sts_pkg::ST_SORT_WB: begin
            state_in = i_last ? sts_pkg::ST_SRCH_START : sts_pkg::ST_SORT_RD;
         end
         sts_pkg::ST_SRCH_START: begin
            state_in = step_go ? sts_pkg::ST_SRCH_CMP : sts_pkg::ST_DONE;
         end
         sts_pkg::ST_SRCH_CMP: begin
            if (probe_hit || !step_go) begin
               state_in = sts_pkg::ST_DONE;
            end
         end
         sts_pkg::ST_DONE: begin
            if (rsp_slot_free) begin
               state_in = sts_pkg::ST_IDLE;
            end
         end
         default: state_in = sts_pkg::ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      count_in     = count_ff;
      sorted_in    = sorted_ff;
      ovf_in       = ovf_ff;
      key_in       = key_ff;
      pivot_in     = pivot_ff;
      i_in         = i_ff;
      x_in         = x_ff;
      lo_in        = lo_ff;
      lim_in       = lim_ff;
      mid_in       = mid_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_we       = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_addr  = '0;
      case (state_ff)
         sts_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  sts_pkg::REQ_LOAD: begin
                     if (count_ff < CNT_W'(sts_pkg::TABLE_DEPTH)) begin
                        ram_we      = 1'b1;
                        ram_wr_addr = count_ff[IDX_W-1:0];
                        ram_wr_data = req_tdata;
                        count_in    = count_ff + CNT_W'(1);
                        sorted_in   = 1'b0;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  sts_pkg::REQ_SEARCH: begin
                     key_in = req_tdata;
                     i_in   = '0;
                  end
                  sts_pkg::REQ_CLEAR: begin
                     count_in  = '0;
                     ovf_in    = 1'b0;
                     sorted_in = 1'b1;
                  end
                  default: begin
                     // unused code, dropped
                  end
               endcase
            end
         end
         sts_pkg::ST_SORT_RD: begin
            ram_rd_addr = i_ff;
         end
         sts_pkg::ST_SORT_GET: begin
            pivot_in    = ram_rd_data;
            ram_rd_addr = '0;
            x_in        = '0;
         end
         sts_pkg::ST_SORT_SCAN: begin
            // entry i lives in pivot, its ram copy is stale so x == i is skipped
            if ((x_ff != i_ff) && ($signed(pivot_ff) < $signed(ram_rd_data))) begin
               ram_we      = 1'b1;
               ram_wr_addr = x_ff;
               ram_wr_data = pivot_ff;
               pivot_in    = ram_rd_data;
            end
            ram_rd_addr = x_ff + IDX_W'(1);
            x_in        = x_ff + IDX_W'(1);
         end
         sts_pkg::ST_SORT_WB: begin
            ram_we      = 1'b1;
            ram_wr_addr = i_ff;
            ram_wr_data = pivot_ff;
            i_in        = i_ff + IDX_W'(1);
            if (i_last) begin
               sorted_in = 1'b1;
            end
         end
         sts_pkg::ST_SRCH_START: begin
            lo_in       = step_lo;
            lim_in      = step_lim;
            mid_in      = step_mid;
            ram_rd_addr = step_mid;
            found_in    = 1'b0;
            pos_in      = '0;
         end
         sts_pkg::ST_SRCH_CMP: begin
            lo_in       = step_lo;
            lim_in      = step_lim;
            mid_in      = step_mid;
            ram_rd_addr = step_mid;
            found_in    = probe_hit;
            pos_in      = probe_hit ? mid_ff : '0;
         end
         sts_pkg::ST_DONE: begin
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sts_pkg::RSP_W'({ovf_ff, count_ff, pos_ff, found_ff});
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sts_pkg::ST_IDLE;
         count_ff     <= '0;
         sorted_ff    <= 1'b1;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      pivot_ff    <= pivot_in;
      i_ff        <= i_in;
      x_ff        <= x_in;
      lo_ff       <= lo_in;
      lim_ff      <= lim_in;
      mid_ff      <= mid_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(sts_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // probes only ever run on a sorted table
   a_search_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sts_pkg::ST_SRCH_CMP) |-> (sorted_ff && !ram_we))
      else $error("search probe on unsorted table or with a write");

   // a swap during the sweep never lands on the held entry
   a_swap_addr: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sts_pkg::ST_SORT_SCAN) && ram_we) |-> (ram_wr_addr != i_ff))
      else $error("sweep swap wrote the held entry");

   // a load with room grows the table by one
   a_load_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == sts_pkg::REQ_LOAD) &&
       (count_ff < CNT_W'(sts_pkg::TABLE_DEPTH)))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)) && !sorted_ff)
      else $error("load did not append");

endmodule

>>> test/tb.sv
// self-checking testbench for the sorted table search block

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int QUIET_ITEMS   = 100;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int DRAIN_CYCLES  = 50;
   localparam int REPORT_LINES  = 40;
   // worst case: every item re-sorts a full table and also waits out the longest
   // sender gap and receiver stall, summed over all transactions, so the watchdog
   // sits several times above that total
   localparam int CYCLE_LIMIT   = 40_000_000;
   localparam int VAL_MAX       = 2147483647;
   localparam int VAL_MIN       = -2147483647 - 1;

   // request code with no meaning, the block must swallow it silently
   localparam logic [sts_pkg::KIND_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic                      found;
      logic [sts_pkg::IDX_W-1:0] position;
      logic [sts_pkg::CNT_W-1:0] count;
      logic                      overflow;
   } lookup_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [sts_pkg::DATA_W-1:0]  req_tdata = '0;
   logic [sts_pkg::KIND_W-1:0]  req_tuser = sts_pkg::REQ_LOAD;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [sts_pkg::RSP_W-1:0]   rsp_tdata;

   // shadow copy of the block state, updated on every accepted transaction
   int                 shadow_table [sts_pkg::TABLE_DEPTH];
   int                 shadow_count;
   bit                 shadow_sorted;
   bit                 shadow_overflow;
   lookup_result_type  expected_lookups [$];

   // run control and counters for the stimulus, the result sink, the checker and the watchdog
   bit                 idling_on;
   int                 hold_off_cycles;
   int                 cycle_count;
   int                 mismatch_count;

   // coverage tallies for the closing summary
   int                 loads_sent, clears_sent, unused_sent, searches_sent;
   int                 lookups_checked, hits_checked, overflow_checked;

   sorted_table_binary_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // value drawn in one of several styles so that duplicates and extremes turn up
   function automatic int pick_value(input int style);
      int corners [7];
      corners = '{VAL_MIN, VAL_MAX, 0, -1, 1, VAL_MIN + 1, VAL_MAX - 1};
      case (style)
         0: return $signed($urandom);
         1: return $urandom_range(0, 16) - 8;
         2: return corners[$urandom_range(0, 6)];
         default: return ($urandom_range(0, 1) != 0) ? $signed($urandom)
                                                      : $urandom_range(0, 40) - 20;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_LINES)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // exchange sort into ascending order, same pairwise swap pattern as the block
   task automatic sort_shadow();
      int t;
      for (int i = 0; i < shadow_count; i++) begin
         for (int x = 0; x < shadow_count; x++) begin
            if (shadow_table[i] < shadow_table[x]) begin
               t = shadow_table[i];
               shadow_table[i] = shadow_table[x];
               shadow_table[x] = t;
            end
         end
      end
   endtask

   // applies one accepted transaction to the shadow state, queues a lookup result
   task automatic track_request(input logic [sts_pkg::KIND_W-1:0] kind, input int value);
      lookup_result_type res;
      int lo, hi, mid, hit;
      case (kind)
         sts_pkg::REQ_LOAD: begin
            loads_sent++;
            if (shadow_count < sts_pkg::TABLE_DEPTH) begin
               shadow_table[shadow_count] = value;
               shadow_count++;
               shadow_sorted = 1'b0;
            end else begin
               shadow_overflow = 1'b1;
            end
         end
         sts_pkg::REQ_CLEAR: begin
            clears_sent++;
            shadow_count    = 0;
            shadow_overflow = 1'b0;
            shadow_sorted   = 1'b1;
         end
         sts_pkg::REQ_SEARCH: begin
            searches_sent++;
            if (!shadow_sorted) begin
               sort_shadow();
               shadow_sorted = 1'b1;
            end
            lo  = 0;
            hi  = shadow_count - 1;
            hit = -1;
            // midpoint search, an empty table never enters the loop
            while (lo <= hi && hit < 0) begin
               mid = (lo + hi) / 2;
               if (shadow_table[mid] == value) hit = mid;
               else if (shadow_table[mid] > value) hi = mid - 1;
               else lo = mid + 1;
            end
            res.found    = (hit >= 0);
            res.position = (hit >= 0) ? hit[sts_pkg::IDX_W-1:0] : '0;
            res.count    = shadow_count[sts_pkg::CNT_W-1:0];
            res.overflow = shadow_overflow;
            expected_lookups.push_back(res);
         end
         default: begin
            unused_sent++;
         end
      endcase
   endtask

   // offers one transaction from the falling edge and holds it until accepted
   task automatic send_item(input logic [sts_pkg::KIND_W-1:0] kind, input int value);
      int gap;
      gap = idling_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      track_request(kind, value);
   endtask

   // search key: often a stored value, sometimes a neighbour or a fresh value
   function automatic int pick_key(input int style);
      int idx;
      if (shadow_count > 0 && $urandom_range(0, 9) < 6) begin
         idx = $urandom_range(0, shadow_count - 1);
         if ($urandom_range(0, 4) == 0)
            return shadow_table[idx] + (($urandom_range(0, 1) != 0) ? 1 : -1);
         return shadow_table[idx];
      end
      return pick_value(style);
   endfunction

   // result sink: random stalls, plus a long hold-off when a test asks for one
   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on) stall_left = pick_gap();
         end
      end
   end

   // compares every result transaction with the oldest queued lookup
   always @(posedge clock) begin : result_check
      lookup_result_type want;
      lookup_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.found    = rsp_tdata[0];
         got.position = rsp_tdata[sts_pkg::IDX_W:1];
         got.count    = rsp_tdata[sts_pkg::IDX_W+sts_pkg::CNT_W:sts_pkg::IDX_W+1];
         got.overflow = rsp_tdata[sts_pkg::IDX_W+sts_pkg::CNT_W+1];
         if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, data %h", rsp_tdata));
         end else begin
            want = expected_lookups.pop_front();
            lookups_checked++;
            if (want.found)    hits_checked++;
            if (want.overflow) overflow_checked++;
            if (got.found !== want.found)
               report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
            if (got.position !== want.position)
               report_mismatch($sformatf("position %0d, want %0d",
                                         got.position, want.position));
            if (got.count !== want.count)
               report_mismatch($sformatf("table_count %0d, want %0d",
                                         got.count, want.count));
            if (got.overflow !== want.overflow)
               report_mismatch($sformatf("overflow %0b, want %0b",
                                         got.overflow, want.overflow));
         end
      end
   end

   // watchdog on the cycle count
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_lookups.size());
      $display("CHECK FAILED");
      $finish;
   end

   // extremes, every request code, empty table, duplicates, re-sort after a load
   task automatic test_basic_ops();
      idling_on = 1'b0;
      send_item(sts_pkg::REQ_SEARCH, 0);            // empty table
      send_item(sts_pkg::REQ_LOAD,   VAL_MAX);
      send_item(sts_pkg::REQ_LOAD,   VAL_MIN);
      send_item(sts_pkg::REQ_LOAD,   0);
      send_item(sts_pkg::REQ_LOAD,   -1);
      send_item(sts_pkg::REQ_LOAD,   5);
      send_item(sts_pkg::REQ_LOAD,   5);            // duplicate key
      send_item(REQ_UNUSED,          32'h5A5A_A5A5);
      send_item(sts_pkg::REQ_SEARCH, VAL_MIN);
      send_item(sts_pkg::REQ_SEARCH, VAL_MAX);
      send_item(sts_pkg::REQ_SEARCH, 5);
      send_item(sts_pkg::REQ_SEARCH, 0);
      send_item(sts_pkg::REQ_SEARCH, -1);
      send_item(sts_pkg::REQ_SEARCH, 7);
      send_item(sts_pkg::REQ_SEARCH, 4);
      send_item(sts_pkg::REQ_LOAD,   -100);         // table goes unsorted again
      send_item(sts_pkg::REQ_SEARCH, -100);
      send_item(sts_pkg::REQ_CLEAR,  0);
      send_item(sts_pkg::REQ_SEARCH, 5);            // empty after clear
   endtask

   // fills the table, drops two loads, then checks the top index and the sticky flag
   task automatic test_full_table();
      idling_on = 1'b0;
      send_item(sts_pkg::REQ_CLEAR, 0);
      for (int i = 0; i < sts_pkg::TABLE_DEPTH; i++) begin
         if (i == 0) send_item(sts_pkg::REQ_LOAD, VAL_MAX);
         else if (i == sts_pkg::TABLE_DEPTH - 1) send_item(sts_pkg::REQ_LOAD, VAL_MIN);
         else send_item(sts_pkg::REQ_LOAD, $signed($urandom));
      end
      send_item(sts_pkg::REQ_LOAD, 1);
      send_item(sts_pkg::REQ_LOAD, 2);
      send_item(sts_pkg::REQ_SEARCH, VAL_MIN);
      send_item(sts_pkg::REQ_SEARCH, VAL_MAX);
      send_item(sts_pkg::REQ_SEARCH, pick_key(0));
      send_item(sts_pkg::REQ_CLEAR, 0);
      send_item(sts_pkg::REQ_SEARCH, 0);            // flag must be gone after the clear
   endtask

   // receiver holds off while searches keep coming, so the block backs up
   task automatic test_receiver_hold_off();
      idling_on = 1'b0;
      send_item(sts_pkg::REQ_CLEAR, 0);
      repeat (10) send_item(sts_pkg::REQ_LOAD, pick_value(1));
      hold_off_cycles = HOLD_OFF_LEN;
      repeat (16) send_item(sts_pkg::REQ_SEARCH, pick_key(1));
   endtask

   // one stretch of back-to-back traffic on both sides
   task automatic test_quiet_stretch();
      idling_on = 1'b0;
      send_item(sts_pkg::REQ_CLEAR, 0);
      for (int n = 0; n < QUIET_ITEMS; n++) begin
         if ($urandom_range(0, 2) == 0) send_item(sts_pkg::REQ_LOAD, pick_value(3));
         else send_item(sts_pkg::REQ_SEARCH, pick_key(3));
      end
   endtask

   // fill-then-search sequences of random size, with noise between the searches
   task automatic test_random_sequences();
      int sent, entries, lookups, style, r;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         idling_on = ($urandom_range(0, 3) != 0);
         style = $urandom_range(0, 3);
         r = $urandom_range(0, 99);
         // mostly small tables, a few that run past the end
         if (r < 5)       entries = 0;
         else if (r < 80) entries = $urandom_range(1, 12);
         else if (r < 94) entries = $urandom_range(13, 40);
         else             entries = $urandom_range(60, 70);
         if ($urandom_range(0, 9) != 0) begin
            send_item(sts_pkg::REQ_CLEAR, pick_value(0));
            sent++;
         end
         repeat (entries) begin
            send_item(sts_pkg::REQ_LOAD, pick_value(style));
            sent++;
         end
         lookups = $urandom_range(3, 10);
         repeat (lookups) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
               send_item(REQ_UNUSED, pick_value(0));
            end else if (r < 14) begin
               send_item(sts_pkg::REQ_LOAD, pick_value(style));
               sent++;
            end else if (r < 16) begin
               send_item(sts_pkg::REQ_CLEAR, pick_value(0));
               sent++;
            end else begin
               send_item(sts_pkg::REQ_SEARCH, pick_key(style));
               sent++;
            end
         end
      end
   endtask

   initial begin : main_sequence
      mismatch_count  = 0;
      hold_off_cycles = 0;
      idling_on       = 1'b0;
      shadow_count    = 0;
      shadow_sorted   = 1'b1;
      shadow_overflow = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_full_table();
      test_receiver_hold_off();
      test_quiet_stretch();
      test_random_sequences();

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_lookups.size() == 0);
      // trailing loads and clears give no result, so a drain follows before the summary
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads, %0d clears, %0d unused codes, %0d searches",
               loads_sent, clears_sent, unused_sent, searches_sent);
      $display("checked %0d results: %0d hits, %0d with overflow set, %0d mismatches",
               lookups_checked, hits_checked, overflow_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
